/* rtl/hdic_pkg.sv */
`timescale 1ns / 1ps

package hdic_pkg;

    // pipeline depth, input to output register
    localparam int NSTG = 12;

    // restoring dividers: width of the numerator/quotient word, steps per stage
    localparam int DIV_W     = 18;
    localparam int DIV_STEPS = 6;
    localparam int DEN_W     = 9;

    localparam logic [11:0] SEG_SPLIT = 12'd1712;
    localparam logic [17:0] SEG1_OFS  = 18'd2048;
    localparam logic [17:0] SEG2_OFS  = 18'd5790;
    localparam logic [11:0] TEMP_OFS  = 12'd397;
    localparam logic [9:0]  LOG_K     = 10'd980;
    localparam logic [9:0]  MAG_A     = 10'd881;
    localparam logic [12:0] MAG_2A    = 13'd1762;
    localparam int          MAG_NUM   = 24310;
    localparam logic [14:0] LOG_OFS   = 15'd20000;
    localparam logic [8:0]  MAG_B     = 9'd243;
    localparam logic [5:0]  ROUND_DEW = 6'd51;

    // reciprocals: x*M >> S equals x/d over the ranges used here
    localparam logic [16:0] RECIP_SEG = 17'd82242;  // /102 >>23, /51 >>22
    localparam logic [15:0] RECIP_10  = 16'd52429;  // >>19
    localparam logic [11:0] RECIP_80  = 12'd3277;   // >>18
    localparam logic [12:0] RECIP_100 = 13'd5243;   // >>19
    localparam logic [14:0] RECIP_43  = 15'd24386;  // >>20

    // quotient count for 24310/den goes up to this many thresholds
    localparam int QD_N = 31;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [DIV_W-1:0] nq;
    } t_div;

    function automatic t_div div_steps(input t_div d, input logic [DEN_W-1:0] den);
        t_div           r;
        logic [DEN_W:0] rem_w;
        r = d;
        for (int i = 0; i < DIV_STEPS; i++) begin
            rem_w = {r.rem, r.nq[DIV_W-1]};
            r.nq  = {r.nq[DIV_W-2:0], 1'b0};
            if (rem_w >= {1'b0, den}) begin
                rem_w   = rem_w - {1'b0, den};
                r.nq[0] = 1'b1;
            end
            r.rem = rem_w[DEN_W-1:0];
        end
        return r;
    endfunction

endpackage

/* rtl/humidity_dewpoint_integer_compensation.sv */
`timescale 1ns / 1ps

// channel  | dir | fields (low bit up)                                   | handshake
// s_axis   | in  | tdata: humidity_ticks[11:0], temperature_ticks[25:12] | tvalid/tready
// m_axis   | out | tdata: temperature_tenths, humidity_percent, dewpoint | tvalid/tready
//          |     | tuser: dew_valid                                      |
// One word per cycle in and out while the output is not stalled, through a 12-stage pipeline.
// The deepest logic sits in three stages of six restoring divider steps each,
// with separate dividers for the log and Magnus quotients running side by side.
// Synchronous active-low reset clears the valid bits only.
// A stall on the output freezes every stage; no word is dropped or repeated.

module humidity_dewpoint_integer_compensation
    import hdic_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // humidity_ticks[11:0], temperature_ticks[25:12]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // temperature_tenths[11:0], humidity_percent[18:12],
                                          // dewpoint_tenths[30:19]
    output logic        o_m_axis_tuser    // dew_valid[0]
);

    logic [NSTG-1:0] r_vld;
    logic            advance;

    assign advance         = ~r_vld[NSTG-1] | i_m_axis_tready;
    assign o_s_axis_tready = advance;
    assign o_m_axis_tvalid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (advance) begin
            r_vld <= {r_vld[NSTG-2:0], i_s_axis_tvalid};
        end
    end

    // ---------------- stage 0: temperature, linear humidity ----------------
    logic [11:0]        s0_h;
    logic [13:0]        s0_tt;
    logic [29:0]        s0_tprod;
    logic signed [11:0] n_temp;
    logic               s0_seg1;
    logic [17:0]        s0_p36;
    logic [17:0]        s0_num;
    logic [34:0]        s0_lprod;
    logic [10:0]        n_rh10;

    always_comb begin
        s0_h     = i_s_axis_tdata[11:0];
        s0_tt    = i_s_axis_tdata[25:12];
        s0_tprod = 30'(s0_tt) * 30'(RECIP_10);
        n_temp   = $signed({1'b0, s0_tprod[29:19]}) - $signed(TEMP_OFS);
        s0_seg1  = s0_h < SEG_SPLIT;
        s0_p36   = 18'(s0_h) * 18'd36;
        if (s0_seg1) begin
            s0_num = (s0_p36 < SEG1_OFS) ? '0 : s0_p36 - SEG1_OFS;
        end else begin
            s0_num = 18'(s0_h) * 18'd14 + SEG2_OFS;
        end
        s0_lprod = 35'(s0_num) * 35'(RECIP_SEG);
        n_rh10   = s0_seg1 ? s0_lprod[33:23] : s0_lprod[32:22];
    end

    logic signed [11:0] r_temp [NSTG];
    logic [10:0]        r_rh10;

    // ---------------- stage 1: round, temperature fractions ----------------
    logic [26:0]        s1_rprod;
    logic [6:0]         s1_rhl;
    logic [6:0]         n_rhl;
    logic [10:0]        s1_mag;
    logic [22:0]        s1_p80;
    logic [26:0]        s1_p10;
    logic signed [5:0]  n_t80;
    logic signed [8:0]  n_t10;

    always_comb begin
        s1_rprod = 27'(r_rh10 + 11'd5) * 27'(RECIP_10);
        s1_rhl   = s1_rprod[25:19];
        n_rhl    = (s1_rhl > 7'd98) ? 7'd100 : s1_rhl;
        s1_mag   = r_temp[0][11] ? 11'(-r_temp[0]) : 11'(r_temp[0]);
        s1_p80   = 23'(s1_mag) * 23'(RECIP_80);
        s1_p10   = 27'(s1_mag) * 27'(RECIP_10);
        n_t80    = r_temp[0][11] ? -$signed({1'b0, s1_p80[22:18]})
                                 : $signed({1'b0, s1_p80[22:18]});
        n_t10    = r_temp[0][11] ? -$signed({1'b0, s1_p10[26:19]})
                                 : $signed({1'b0, s1_p10[26:19]});
    end

    logic [6:0]        r_rhl;
    logic signed [5:0] r_t80;
    logic signed [8:0] r_t10;

    // ---------------- stage 2: compensated humidity, divider setup ----------------
    logic signed [8:0] s2_sum;
    logic [6:0]        n_x;
    logic [6:0]        s2_qmag;
    logic [16:0]       s2_qnum;
    t_div              n_dq;
    t_div              n_dl;
    logic [DEN_W-1:0]  n_qden;
    logic [DEN_W-1:0]  n_lden;

    always_comb begin
        s2_sum = $signed({2'b0, r_rhl}) + 9'(r_t80) - 9'sd3;
        if (s2_sum < 0) begin
            n_x = '0;
        end else if (s2_sum > 9'sd100) begin
            n_x = 7'd100;
        end else begin
            n_x = s2_sum[6:0];
        end
        s2_qmag  = r_t10[8] ? 7'(-r_t10) : 7'(r_t10);
        s2_qnum  = 17'(s2_qmag) * 17'(MAG_A);
        n_qden   = 9'($signed({1'b0, MAG_B}) + 10'(r_t10));
        n_lden   = (n_x < 7'd8) ? 9'd8 : 9'(n_x);
        n_dq.rem = '0;
        n_dq.nq  = DIV_W'(s2_qnum);
        n_dl.rem = '0;
        n_dl.nq  = DIV_W'(LOG_K);
    end

    logic [6:0]       r_rh   [2:NSTG-1];
    logic             r_qneg [2:5];
    logic [DEN_W-1:0] r_qden [2:5];
    logic [DEN_W-1:0] r_lden [2:5];
    t_div             r_dq   [2:5];
    t_div             r_dl   [2:5];

    // ---------------- stage 6: log approximation ----------------
    logic [6:0]        s6_x;
    logic [6:0]        s6_lq;
    logic [9:0]        s6_dif;
    logic [25:0]       s6_ap;
    logic [10:0]       s6_x19;
    logic [26:0]       s6_p19;
    logic [12:0]       s6_x67;
    logic [25:0]       s6_p67;
    logic [8:0]        s6_lg;
    logic [7:0]        n_lg;
    logic [8:0]        s6_qv;
    logic signed [9:0] n_q;

    always_comb begin
        s6_x   = r_rh[5];
        s6_lq  = r_dl[5].nq[6:0];
        s6_dif = LOG_K - 10'(s6_lq);
        s6_ap  = 26'(s6_dif) * 26'(RECIP_10);
        s6_x19 = 11'(s6_x) * 11'd19;
        s6_p19 = 27'(s6_x19) * 27'(RECIP_10);
        s6_x67 = 13'(s6_x) * 13'd67;
        s6_p67 = 26'(s6_x67) * 26'(RECIP_100);
        if (s6_x < 7'd31) begin
            s6_lg = 9'(s6_ap[25:19]) + 9'(s6_p19[26:19]) - 9'd4;
        end else if (s6_x > 7'd51 && s6_x < 7'd81) begin
            s6_lg = 9'(s6_ap[25:19]) + 9'(s6_p67[25:19]) + 9'd42;
        end else begin
            s6_lg = 9'(s6_ap[25:19]) + 9'(s6_p67[25:19]) + 9'd39;
        end
        if (s6_x == 7'd1) begin
            n_lg = '0;
        end else if (s6_x < 7'd8) begin
            n_lg = 8'(s6_x) * 8'd11 + 8'd11;
        end else if (s6_lg > 9'd200) begin
            n_lg = 8'd200;
        end else begin
            n_lg = s6_lg[7:0];
        end
        s6_qv = r_dq[5].nq[8:0];
        n_q   = r_qneg[5] ? -$signed({1'b0, s6_qv}) : $signed({1'b0, s6_qv});
    end

    logic [7:0]        r_lg;
    logic signed [9:0] r_q6;

    // ---------------- stage 7: log offset ----------------
    logic [14:0] n_lmag;
    assign n_lmag = LOG_OFS - 15'(r_lg) * 15'd100;

    logic [14:0]       r_lmag;
    logic signed [9:0] r_q7;

    // ---------------- stage 8: k and denominator ----------------
    logic [29:0]        s8_kp;
    logic signed [11:0] n_k;
    logic signed [12:0] n_den;

    always_comb begin
        s8_kp = 30'(r_lmag) * 30'(RECIP_43);
        n_k   = (12'(r_q7) <<< 1) - $signed({2'b0, s8_kp[29:20]});
        n_den = $signed(MAG_2A) - 13'(n_k);
    end

    logic signed [11:0] r_k8;
    logic signed [12:0] r_den;

    // ---------------- stage 9: 24310/den by threshold count ----------------
    logic [QD_N-1:0] s9_hit;

    for (genvar g = 0; g < QD_N; g++) begin : g_th
        localparam logic [15:0] TH = 16'(MAG_NUM / (g + 1));
        assign s9_hit[g] = (r_den > 0) && ($signed(TH) >= 16'(r_den));
    end

    logic [4:0] n_qd;
    logic       n_dv;

    always_comb begin
        n_qd = '0;
        for (int i = 0; i < QD_N; i++) begin
            n_qd = n_qd + 5'(s9_hit[i]);
        end
        n_dv = (r_den != 0);
    end

    logic [4:0]         r_qd;
    logic signed [11:0] r_k9;
    logic               r_dv [9:NSTG-1];

    // ---------------- stage 10: dew product and rounding ----------------
    logic signed [17:0] s10_prod;
    logic signed [17:0] n_dew;

    always_comb begin
        s10_prod = 18'($signed({1'b0, r_qd})) * 18'(r_k9);
        if (!r_dv[9]) begin
            n_dew = '0;
        end else if (s10_prod < 0) begin
            n_dew = s10_prod - $signed({12'b0, ROUND_DEW});
        end else begin
            n_dew = s10_prod + $signed({12'b0, ROUND_DEW});
        end
    end

    logic signed [17:0] r_dew;

    // ---------------- stage 11: divide by ten toward zero ----------------
    logic [14:0] s11_mag;
    logic [30:0] s11_p;
    logic [11:0] n_dp;

    always_comb begin
        s11_mag = r_dew[17] ? 15'(-r_dew) : 15'(r_dew);
        s11_p   = 31'(s11_mag) * 31'(RECIP_10);
        n_dp    = r_dew[17] ? -s11_p[30:19] : s11_p[30:19];
    end

    logic [11:0] r_dp;

    // ---------------- payload registers: hold while stalled ----------------
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_temp[0] <= n_temp;
            for (int i = 1; i < NSTG; i++) begin
                r_temp[i] <= r_temp[i-1];
            end
            r_rh10 <= n_rh10;
            r_rhl  <= n_rhl;
            r_t80  <= n_t80;
            r_t10  <= n_t10;

            r_rh[2]   <= n_x;
            r_qneg[2] <= r_t10[8];
            r_qden[2] <= n_qden;
            r_lden[2] <= n_lden;
            r_dq[2]   <= n_dq;
            r_dl[2]   <= n_dl;
            for (int i = 3; i < NSTG; i++) begin
                r_rh[i] <= r_rh[i-1];
            end
            for (int i = 3; i <= 5; i++) begin
                r_qneg[i] <= r_qneg[i-1];
                r_qden[i] <= r_qden[i-1];
                r_lden[i] <= r_lden[i-1];
                r_dq[i]   <= div_steps(r_dq[i-1], r_qden[i-1]);
                r_dl[i]   <= div_steps(r_dl[i-1], r_lden[i-1]);
            end

            r_lg   <= n_lg;
            r_q6   <= n_q;
            r_lmag <= n_lmag;
            r_q7   <= r_q6;
            r_k8   <= n_k;
            r_den  <= n_den;
            r_qd   <= n_qd;
            r_k9   <= r_k8;
            r_dv[9] <= n_dv;
            for (int i = 10; i < NSTG; i++) begin
                r_dv[i] <= r_dv[i-1];
            end
            r_dew <= n_dew;
            r_dp  <= n_dp;
        end
    end

    assign o_m_axis_tdata = {1'b0, r_dp, r_rh[NSTG-1], r_temp[NSTG-1]};
    assign o_m_axis_tuser = r_dv[NSTG-1];

endmodule

/* tb/tb_humidity_dewpoint_integer_compensation.sv */
`timescale 1ns / 1ps

module tb_humidity_dewpoint_integer_compensation
    import hdic_pkg::*;
();

    typedef struct packed {
        logic [11:0] temp_tenths;
        logic [6:0]  rh_percent;
        logic [11:0] dew_tenths;
        logic        dew_ok;
    } t_reading;

    localparam int LIMIT_CYCLES = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;

    logic [31:0] sample_q[$];
    t_reading    reading_q[$];
    int          idle_pct;
    int          stall_pct;
    int          n_err;
    int          n_sent;
    int          n_recv;
    int          cycles;
    bit          hold_off;
    bit          in_taken;

    humidity_dewpoint_integer_compensation DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int lin_rh(input int s);
        int rh;
        int num;
        if (s < 1712) begin
            num = 36 * s - 2048;
            rh = (num < 0) ? 0 : num / 102;
        end else begin
            rh = (14 * s + 5790) / 51;
        end
        rh = (rh + 5) / 10;
        if (rh > 98) rh = 100;
        return rh;
    endfunction

    function automatic int log_x100(input int x);
        int lg;
        if (x == 1) return 0;
        if (x < 8) return 11 * x + 11;
        lg = (980 - 980 / x) / 10;
        if (x < 31) lg += (19 * x) / 10 - 4;
        else if (x > 51 && x < 81) lg += (67 * x) / 100 + 42;
        else lg += (67 * x) / 100 + 39;
        if (lg > 200) lg = 200;
        return lg;
    endfunction

    // SV integer division truncates toward zero, as needed here
    function automatic t_reading convert_sample(input logic [31:0] w);
        t_reading r;
        int h, tt, temp, rh, k, q, den, dew;
        h = int'(w[11:0]);
        tt = int'(w[25:12]);
        temp = tt / 10 - 397;
        rh = lin_rh(h) + (temp / 80 - 3);
        if (rh < 0) rh = 0;
        if (rh > 100) rh = 100;
        k = (100 * log_x100(rh) - 20000) / 43;
        q = (881 * (temp / 10)) / (243 + temp / 10);
        k += 2 * q;
        den = 1762 - k;
        r.dew_ok = 1'b1;
        if (den == 0) begin
            dew = 0;
            r.dew_ok = 1'b0;
        end else begin
            dew = (24310 / den) * k;
            dew = (dew < 0) ? dew - 51 : dew + 51;
            dew = dew / 10;
        end
        r.temp_tenths = temp[11:0];
        r.rh_percent = rh[6:0];
        r.dew_tenths = dew[11:0];
        return r;
    endfunction

    function automatic logic [31:0] pack_sample(input int h, input int tt);
        logic [31:0] w;
        w = '0;
        w[11:0] = h[11:0];
        w[25:12] = tt[13:0];
        return w;
    endfunction

    // drive on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= '0;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
            if (i_s_axis_tvalid && !in_taken) begin
                // hold the word until accepted
            end else if (sample_q.size() > 0 && !hold_off &&
                         $urandom_range(99) >= idle_pct) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= sample_q[0];
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_reading got;
        t_reading want;
        cycles <= cycles + 1;
        in_taken <= i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            reading_q.push_back(convert_sample(i_s_axis_tdata));
            void'(sample_q.pop_front());
            n_sent <= n_sent + 1;
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.temp_tenths = o_m_axis_tdata[11:0];
            got.rh_percent  = o_m_axis_tdata[18:12];
            got.dew_tenths  = o_m_axis_tdata[30:19];
            got.dew_ok      = o_m_axis_tuser;
            n_recv <= n_recv + 1;
            if (reading_q.size() == 0) begin
                n_err = n_err + 1;
                if (n_err <= 10) $display("unexpected word %h user %b", o_m_axis_tdata,
                                          o_m_axis_tuser);
            end else begin
                want = reading_q.pop_front();
                if (got !== want) begin
                    n_err = n_err + 1;
                    if (n_err <= 10)
                        $display("mismatch: exp %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                                 $signed(want.temp_tenths), want.rh_percent,
                                 $signed(want.dew_tenths), want.dew_ok,
                                 $signed(got.temp_tenths), got.rh_percent,
                                 $signed(got.dew_tenths), got.dew_ok);
                end
            end
        end
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic push_random(input int n);
        int h;
        int tt;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(3))
                0: h = $urandom_range(4095);
                1: h = $urandom_range(1800, 1600);
                2: h = $urandom_range(200, 0);
                default: h = $urandom_range(3200, 300);
            endcase
            case ($urandom_range(3))
                0: tt = $urandom_range(16383);
                1: tt = $urandom_range(7000, 3000);
                2: tt = $urandom_range(100, 0);
                default: tt = $urandom_range(16383, 16000);
            endcase
            sample_q.push_back(pack_sample(h, tt));
        end
    endtask

    task automatic drain();
        while (sample_q.size() > 0 || reading_q.size() > 0) @(posedge i_clk);
    endtask

    initial begin
        int hs[$];
        int ts[$];
        i_rst_n = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        hold_off = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // corners: field extremes, segment split, negative first segment, low rh
        hs = '{0, 4095, 0, 4095, 1711, 1712, 56, 57, 100, 2048, 3000, 1, 4094, 400, 1711};
        ts = '{0, 16383, 16383, 0, 3970, 3970, 5000, 5000, 0, 8191, 16382, 1, 2, 3969, 0};
        foreach (hs[i]) sample_q.push_back(pack_sample(hs[i], ts[i]));
        drain();

        idle_pct = 0;  stall_pct = 0;  push_random(250); drain();
        idle_pct = 85; stall_pct = 0;  push_random(150); drain();
        // with every result back, hold off new input before the stalled run
        hold_off = 1'b1;
        repeat (20) @(posedge i_clk);
        hold_off = 1'b0;
        idle_pct = 0;  stall_pct = 85; push_random(150); drain();
        idle_pct = 7;  stall_pct = 7;  push_random(300); drain();
        repeat (3 * NSTG) @(posedge i_clk);

        $display("covered %0d samples in, %0d results out: corners, segment split,",
                 n_sent, n_recv);
        $display("full input ranges under steady, sparse, stalled and mixed flow");
        if (n_err == 0 && reading_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d errors, %0d results missing", n_err, reading_q.size());
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* humidity_dewpoint_integer_compensation.f */
rtl/hdic_pkg.sv
rtl/humidity_dewpoint_integer_compensation.sv
tb/tb_humidity_dewpoint_integer_compensation.sv
